@@ sv/hbt_pkg.sv @@
// shared constants and register codes for the hydrogen bond test core
package hbt_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int REG_W      = 31;
  localparam int LIM_W      = 18;
  localparam int ESCALE_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [REG_W-1:0]       BOX_RST    = 31'd327680;
  localparam logic [REG_W-1:0]       DA_LIM_RST = 31'd22938;
  localparam logic [REG_W-1:0]       HA_LIM_RST = 31'd16384;
  localparam logic signed [LIM_W-1:0] COS_LIM_RST = -18'sd56756;
  localparam logic [ESCALE_W-1:0]    ESCALE_RST = 24'd1827668;

  localparam logic [REG_W-1:0] COMP_MAX = 31'h7FFF_FFFF;

  localparam int DIST_W      = 32;
  localparam int SQ_W        = 64;
  localparam int RECIP_SHIFT = 62;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X       = 3'd0,
    CFG_BOX_Y       = 3'd1,
    CFG_BOX_Z       = 3'd2,
    CFG_DA_LIMIT    = 3'd3,
    CFG_HA_LIMIT    = 3'd4,
    CFG_COS_LIMIT   = 3'd5,
    CFG_ENERGY_SCALE = 3'd6
  } cfg_idx_t;

endpackage

@@ sv/hbt_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage, with side data
module hbt_div_pipe #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 31,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_vld,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem,
  output logic [TAG_W-1:0] tag_out
);

  logic [NUM_W-1:0] st_vld;
  logic [DEN_W-1:0] st_rem [NUM_W];
  logic [NUM_W-1:0] st_num [NUM_W];
  logic [DEN_W-1:0] st_den [NUM_W];
  logic [NUM_W-1:0] st_quo [NUM_W];
  logic [TAG_W-1:0] st_tag [NUM_W];

  logic [DEN_W-1:0] rem_next [NUM_W];
  logic [NUM_W-1:0] quo_next [NUM_W];

  always_comb begin
    logic [DEN_W-1:0] c_rem;
    logic [NUM_W-1:0] c_num;
    logic [DEN_W-1:0] c_den;
    logic [NUM_W-1:0] c_quo;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;
    for (int k = 0; k < NUM_W; k++) begin
      if (k == 0) begin
        c_rem = '0;
        c_num = num;
        c_den = den;
        c_quo = '0;
      end else begin
        c_rem = st_rem[k-1];
        c_num = st_num[k-1];
        c_den = st_den[k-1];
        c_quo = st_quo[k-1];
      end
      shifted = {c_rem, c_num[NUM_W-1-k]};
      diff    = shifted - {1'b0, c_den};
      ge      = (shifted >= {1'b0, c_den});
      rem_next[k] = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_next[k] = {c_quo[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
    end else if (en) begin
      st_vld <= {st_vld[NUM_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_W; k++) begin
        st_rem[k] <= rem_next[k];
        st_quo[k] <= quo_next[k];
        if (k == 0) begin
          st_num[k] <= num;
          st_den[k] <= den;
          st_tag[k] <= tag_in;
        end else begin
          st_num[k] <= st_num[k-1];
          st_den[k] <= st_den[k-1];
          st_tag[k] <= st_tag[k-1];
        end
      end
    end
  end

  assign out_vld = st_vld[NUM_W-1];
  assign quo     = st_quo[NUM_W-1];
  assign rem     = st_rem[NUM_W-1];
  assign tag_out = st_tag[NUM_W-1];

endmodule

@@ sv/hydrogen_bond_test_core.sv @@
// hydrogen bond test over four atoms with minimum-image distances, fully pipelined
//
//   channel | signals                                  | direction
//   in      | in_valid, in_ready, donor_x .. partner_z | request in
//   out     | out_valid, out_ready, is_bonded          | result out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write in
//
// one request per cycle while the output is not blocked; the pipeline holds the box remainder
// divider (one stage per coordinate bit), the 32 step square root and the 63 stage
// reciprocal divider
// reset clears all valid bits and loads the register defaults; cfg_ready is always high
// the whole pipeline advances together; it holds only when its last stage is full and
// the output register holds a result that is not taken
module hydrogen_bond_test_core #(
  parameter int COORD_WIDTH = hbt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = hbt_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     donor_x,
  input  logic signed [COORD_WIDTH-1:0]     donor_y,
  input  logic signed [COORD_WIDTH-1:0]     donor_z,
  input  logic signed [COORD_WIDTH-1:0]     donor_h_x,
  input  logic signed [COORD_WIDTH-1:0]     donor_h_y,
  input  logic signed [COORD_WIDTH-1:0]     donor_h_z,
  input  logic signed [COORD_WIDTH-1:0]     acceptor_x,
  input  logic signed [COORD_WIDTH-1:0]     acceptor_y,
  input  logic signed [COORD_WIDTH-1:0]     acceptor_z,
  input  logic signed [COORD_WIDTH-1:0]     partner_x,
  input  logic signed [COORD_WIDTH-1:0]     partner_y,
  input  logic signed [COORD_WIDTH-1:0]     partner_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              is_bonded,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hbt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW         = COORD_WIDTH;
  localparam int NPAIR      = 6;
  localparam int NCOMP      = 18;
  localparam int MAG_W      = hbt_pkg::REG_W;
  localparam int SAT_W      = ((CW > MAG_W) ? CW : MAG_W) + 1;
  localparam int SQ_W       = hbt_pkg::SQ_W;
  localparam int SQRT_STEPS = 32;
  localparam int DIST_W     = hbt_pkg::DIST_W;
  localparam int RCP_W      = hbt_pkg::RECIP_SHIFT + 1;
  localparam int ANG_STAGES = 4;
  localparam int ANG_DLY    = RCP_W - ANG_STAGES;
  localparam int LMAG_W     = 65 + FRAC_BITS;
  localparam int RMAG_W     = 83;
  localparam int CMP_W      = (LMAG_W > RMAG_W) ? LMAG_W : RMAG_W;
  localparam int PROD_W     = 88;
  localparam int FLAG_W     = 3;
  localparam logic [PROD_W-1:0] ECONST = PROD_W'(10) << (77 - FRAC_BITS);
  // atoms: donor, hydrogen, acceptor, partner; pairs DH HA DA PH PD AP
  localparam int PA [NPAIR] = '{0, 1, 0, 3, 3, 2};
  localparam int PB [NPAIR] = '{1, 2, 2, 1, 0, 3};
  // reciprocal order: AD, PH, AH, PD
  localparam int RIDX [4] = '{2, 3, 1, 4};

  // configuration registers
  logic [MAG_W-1:0]                   box [3];
  logic [MAG_W-1:0]                   da_lim;
  logic [MAG_W-1:0]                   ha_lim;
  logic signed [hbt_pkg::LIM_W-1:0]   cos_lim;
  logic [hbt_pkg::ESCALE_W-1:0]       e_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box[0]  <= hbt_pkg::BOX_RST;
      box[1]  <= hbt_pkg::BOX_RST;
      box[2]  <= hbt_pkg::BOX_RST;
      da_lim  <= hbt_pkg::DA_LIM_RST;
      ha_lim  <= hbt_pkg::HA_LIM_RST;
      cos_lim <= hbt_pkg::COS_LIM_RST;
      e_scale <= hbt_pkg::ESCALE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hbt_pkg::CFG_BOX_X:        box[0]  <= cfg_data[MAG_W-1:0];
        hbt_pkg::CFG_BOX_Y:        box[1]  <= cfg_data[MAG_W-1:0];
        hbt_pkg::CFG_BOX_Z:        box[2]  <= cfg_data[MAG_W-1:0];
        hbt_pkg::CFG_DA_LIMIT:     da_lim  <= cfg_data[MAG_W-1:0];
        hbt_pkg::CFG_HA_LIMIT:     ha_lim  <= cfg_data[MAG_W-1:0];
        hbt_pkg::CFG_COS_LIMIT:    cos_lim <= cfg_data[hbt_pkg::LIM_W-1:0];
        hbt_pkg::CFG_ENERGY_SCALE: e_scale <= cfg_data[hbt_pkg::ESCALE_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic vn;

  assign adv      = !vn || !out_valid || out_ready;
  assign in_ready = adv;

  // stage A: absolute coordinate differences
  logic signed [CW-1:0] atom [4][3];
  logic [CW-1:0]        abs_c [NCOMP];
  logic [CW-1:0]        a_d   [NCOMP];
  logic                 va;

  always_comb begin
    atom[0][0] = donor_x;    atom[0][1] = donor_y;    atom[0][2] = donor_z;
    atom[1][0] = donor_h_x;  atom[1][1] = donor_h_y;  atom[1][2] = donor_h_z;
    atom[2][0] = acceptor_x; atom[2][1] = acceptor_y; atom[2][2] = acceptor_z;
    atom[3][0] = partner_x;  atom[3][1] = partner_y;  atom[3][2] = partner_z;
  end

  always_comb begin
    logic signed [CW:0] dfx;
    logic signed [CW:0] ndfx;
    for (int p = 0; p < NPAIR; p++) begin
      for (int ax = 0; ax < 3; ax++) begin
        dfx  = {atom[PA[p]][ax][CW-1], atom[PA[p]][ax]}
             - {atom[PB[p]][ax][CW-1], atom[PB[p]][ax]};
        ndfx = -dfx;
        abs_c[p*3+ax] = dfx[CW] ? ndfx[CW-1:0] : dfx[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_d <= abs_c;
    end
  end

  // remainder by the box side, one unit per component
  logic [NCOMP-1:0] rm_vld;
  logic [MAG_W-1:0] rm_rem [NCOMP];
  logic [CW-1:0]    rm_d   [NCOMP];

  for (genvar c = 0; c < NCOMP; c++) begin : g_rem
    hbt_div_pipe #(
      .NUM_W(CW),
      .DEN_W(MAG_W),
      .TAG_W(CW)
    ) u_rem (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .in_vld (va),
      .num    (a_d[c]),
      .den    (box[c % 3]),
      .tag_in (a_d[c]),
      .out_vld(rm_vld[c]),
      .quo    (),
      .rem    (rm_rem[c]),
      .tag_out(rm_d[c])
    );
  end

  // stage B: nearest image magnitude, saturated
  logic [MAG_W-1:0] mag_c [NCOMP];
  logic [MAG_W-1:0] mag_b [NCOMP];
  logic             vb;

  always_comb begin
    logic [SAT_W-1:0] dz;
    logic [MAG_W-1:0] s;
    logic [MAG_W-1:0] r;
    for (int p = 0; p < NPAIR; p++) begin
      for (int ax = 0; ax < 3; ax++) begin
        s  = box[ax];
        r  = rm_rem[p*3+ax];
        dz = SAT_W'(rm_d[p*3+ax]);
        if (s == '0) begin
          mag_c[p*3+ax] = (dz > SAT_W'(hbt_pkg::COMP_MAX)) ? hbt_pkg::COMP_MAX
                                                           : dz[MAG_W-1:0];
        end else if ({r, 1'b0} >= {1'b0, s}) begin
          mag_c[p*3+ax] = s - r;
        end else begin
          mag_c[p*3+ax] = r;
        end
      end
    end
  end

  // stage C: squares, stage D: per pair sums
  logic [2*MAG_W-1:0] sq_c [NCOMP];
  logic [SQ_W-1:0]    sum_d [NPAIR];
  logic               vc;
  logic               vd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (adv) begin
      vb <= rm_vld[0];
      vc <= vb;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_b <= mag_c;
      for (int c = 0; c < NCOMP; c++) begin
        sq_c[c] <= mag_b[c] * mag_b[c];
      end
      for (int p = 0; p < NPAIR; p++) begin
        sum_d[p] <= SQ_W'(sq_c[p*3]) + SQ_W'(sq_c[p*3+1]) + SQ_W'(sq_c[p*3+2]);
      end
    end
  end

  // integer square root, one result bit per stage
  logic [SQ_W-1:0]       sq_n      [NPAIR][SQRT_STEPS];
  logic [SQ_W-1:0]       sq_r      [NPAIR][SQRT_STEPS];
  logic [SQ_W-1:0]       sq_n_next [NPAIR][SQRT_STEPS];
  logic [SQ_W-1:0]       sq_r_next [NPAIR][SQRT_STEPS];
  logic [SQRT_STEPS-1:0] sv;

  always_comb begin
    logic [SQ_W-1:0] cn;
    logic [SQ_W-1:0] cr;
    logic [SQ_W-1:0] sbit;
    logic [SQ_W-1:0] t;
    for (int p = 0; p < NPAIR; p++) begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
        if (j == 0) begin
          cn = sum_d[p];
          cr = '0;
        end else begin
          cn = sq_n[p][j-1];
          cr = sq_r[p][j-1];
        end
        sbit = SQ_W'(1) << (SQ_W - 2 - 2*j);
        t    = cr + sbit;
        if (cn >= t) begin
          sq_n_next[p][j] = cn - t;
          sq_r_next[p][j] = (cr >> 1) + sbit;
        end else begin
          sq_n_next[p][j] = cn;
          sq_r_next[p][j] = cr >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (adv) begin
      sv <= {sv[SQRT_STEPS-2:0], vd};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_n <= sq_n_next;
      sq_r <= sq_r_next;
    end
  end

  logic [DIST_W-1:0] pair_len [NPAIR];
  logic              ve;
  logic [FLAG_W-1:0] e_flags;

  always_comb begin
    logic nz;
    nz = 1'b1;
    for (int p = 0; p < NPAIR; p++) begin
      pair_len[p] = sq_r[p][SQRT_STEPS-1][DIST_W-1:0];
      if (pair_len[p] == '0) begin
        nz = 1'b0;
      end
    end
    e_flags = {nz, (pair_len[2] < {1'b0, da_lim}), (pair_len[1] < {1'b0, ha_lim})};
  end

  assign ve = sv[SQRT_STEPS-1];

  // reciprocals 2^62 / d
  logic [3:0]        rc_vld;
  logic [RCP_W-1:0]  rq     [4];
  logic [DIST_W-1:0] rc_rem [4];
  logic [FLAG_W-1:0] rc_tag [4];

  for (genvar r = 0; r < 4; r++) begin : g_rcp
    hbt_div_pipe #(
      .NUM_W(RCP_W),
      .DEN_W(DIST_W),
      .TAG_W(FLAG_W)
    ) u_rcp (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .in_vld (ve),
      .num    (RCP_W'(1) << hbt_pkg::RECIP_SHIFT),
      .den    (pair_len[RIDX[r]]),
      .tag_in (e_flags),
      .out_vld(rc_vld[r]),
      .quo    (rq[r]),
      .rem    (rc_rem[r]),
      .tag_out(rc_tag[r])
    );
  end

  // angle test: (a^2 + b^2 - c^2) * 2^F < 2 * lim * a * b
  logic [63:0]              aa_f, bb_f, cc_f, ab_f;
  logic [64:0]              p_g;
  logic [63:0]              q_g;
  logic [50:0]              abl_g, abh_g;
  logic                     rneg_g;
  logic [CMP_W-1:0]         lmag_h, rmag_h;
  logic                     lneg_h, rneg_h;
  logic                     ang_i;
  logic [ANG_DLY-1:0]       ang_sh;
  logic [hbt_pkg::LIM_W-1:0] lim_neg;
  logic [hbt_pkg::LIM_W-1:0] lim_abs;
  logic [hbt_pkg::LIM_W:0]   lim2;
  logic [64:0]              lm;
  logic                     lneg_c;

  assign lim_neg = -cos_lim;
  assign lim_abs = cos_lim[hbt_pkg::LIM_W-1] ? lim_neg : cos_lim;
  assign lim2    = {lim_abs, 1'b0};
  assign lneg_c  = (p_g < {1'b0, q_g});
  assign lm      = lneg_c ? ({1'b0, q_g} - p_g) : (p_g - {1'b0, q_g});

  always_ff @(posedge clk) begin
    if (adv) begin
      aa_f   <= pair_len[0] * pair_len[0];
      bb_f   <= pair_len[1] * pair_len[1];
      cc_f   <= pair_len[2] * pair_len[2];
      ab_f   <= pair_len[0] * pair_len[1];
      p_g    <= {1'b0, aa_f} + {1'b0, bb_f};
      q_g    <= cc_f;
      abl_g  <= ab_f[31:0] * lim2;
      abh_g  <= ab_f[63:32] * lim2;
      rneg_g <= cos_lim[hbt_pkg::LIM_W-1];
      lneg_h <= lneg_c;
      rneg_h <= rneg_g;
      lmag_h <= CMP_W'(lm) << FRAC_BITS;
      rmag_h <= (CMP_W'(abh_g) << 32) + CMP_W'(abl_g);
      if (lneg_h && !rneg_h) begin
        ang_i <= 1'b1;
      end else if (!lneg_h && rneg_h) begin
        ang_i <= 1'b0;
      end else if (!lneg_h) begin
        ang_i <= (lmag_h < rmag_h);
      end else begin
        ang_i <= (lmag_h > rmag_h);
      end
      // lines the angle result up with the reciprocal outputs
      ang_sh <= {ang_sh[ANG_DLY-2:0], ang_i};
    end
  end

  // energy test
  logic [63:0]                        att_j, rep_j;
  logic                               vj, fj;
  logic [RCP_W-1:0]                   df_k;
  logic                               vk, fk, gt_k;
  logic [hbt_pkg::ESCALE_W+31:0]      plo_l;
  logic [hbt_pkg::ESCALE_W+30:0]      phi_l;
  logic                               vl, fl, gt_l;
  logic [PROD_W-1:0]                  prod_m;
  logic                               vm, fm, gt_m;
  logic                               bond_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      vj <= 1'b0;
      vk <= 1'b0;
      vl <= 1'b0;
      vm <= 1'b0;
      vn <= 1'b0;
    end else if (adv) begin
      vj <= rc_vld[0];
      vk <= vj;
      vl <= vk;
      vm <= vl;
      vn <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      att_j  <= 64'(rq[2]) + 64'(rq[3]);
      rep_j  <= 64'(rq[0]) + 64'(rq[1]);
      fj     <= (&rc_tag[0]) & ang_sh[ANG_DLY-1];
      gt_k   <= (att_j > rep_j);
      df_k   <= RCP_W'(att_j - rep_j);
      fk     <= fj;
      plo_l  <= e_scale * df_k[31:0];
      phi_l  <= e_scale * df_k[RCP_W-1:32];
      gt_l   <= gt_k;
      fl     <= fk;
      prod_m <= (PROD_W'(phi_l) << 32) + PROD_W'(plo_l);
      gt_m   <= gt_l;
      fm     <= fl;
      bond_n <= fm & gt_m & (prod_m > ECONST);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (vn && adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vn && adv) begin
      is_bonded <= bond_n;
    end
  end

  a_rise_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vn))
    else $error("result appeared without a finished item");

  a_last_holds: assert property (@(posedge clk) disable iff (rst)
    (vn && out_valid && !out_ready) |=> (vn && $stable(bond_n)))
    else $error("last stage changed while blocked");

  a_last_moves: assert property (@(posedge clk) disable iff (rst)
    (vn && in_ready) |=> out_valid)
    else $error("finished item was lost");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!out_valid && !vn && !va))
    else $error("valid bits not cleared by reset");

endmodule
